// ----- rtl/lrsl_pkg.sv -----
// package for the line rasterizer with serpentine led mapping
// holds field widths, register codes, the line descriptor and state types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lrsl_pkg;

  localparam int COORD_W = 6;
  localparam int DIM_W   = 7;
  localparam int COLOR_W = 16;
  localparam int INDEX_W = 12;
  localparam int ERR_W   = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = 7'd15;
  localparam logic [DIM_W-1:0] GRID_HEIGHT_RST = 7'd10;

  // one line, already ordered along its major axis
  typedef struct packed {
    logic [COORD_W-1:0] maj_start;
    logic [COORD_W-1:0] maj_end;
    logic [COORD_W-1:0] min_start;
    logic [COORD_W-1:0] dmaj;
    logic [COORD_W-1:0] dmin;
    logic               min_dec;
    logic               steep;
    logic [COLOR_W-1:0] color;
  } line_desc_t;

  // handshake between queue and its neighbors
  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } q_rd_t;

  typedef enum logic [0:0] {
    BK_IDLE = 1'b0,
    BK_DRAW = 1'b1
  } bk_state_t;

endpackage

`default_nettype wire

// ----- rtl/lrsl_if.sv -----
// channel interfaces: line requests in, pixel writes out
// depends on lrsl_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface lrsl_line_if;
  logic                           valid;
  logic                           ready;
  logic [lrsl_pkg::COORD_W-1:0]   start_x;
  logic [lrsl_pkg::COORD_W-1:0]   start_y;
  logic [lrsl_pkg::COORD_W-1:0]   end_x;
  logic [lrsl_pkg::COORD_W-1:0]   end_y;
  logic [lrsl_pkg::COLOR_W-1:0]   pixel_color;

  modport source (output valid, start_x, start_y, end_x, end_y, pixel_color, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, pixel_color, output ready);
endinterface

interface lrsl_pix_if;
  logic                           valid;
  logic                           ready;
  logic [lrsl_pkg::INDEX_W-1:0]   led_index;
  logic                           on_grid;
  logic [lrsl_pkg::COLOR_W-1:0]   write_color;
  logic                           last_pixel;

  modport source (output valid, led_index, on_grid, write_color, last_pixel, input ready);
  modport sink   (input valid, led_index, on_grid, write_color, last_pixel, output ready);
endinterface

`default_nettype wire

// ----- rtl/lrsl_front.sv -----
// front end: accepts a line request, swaps axes for steep lines, orders ends
// depends on lrsl_pkg and lrsl_line_if; feeds lrsl_queue
`timescale 1ns / 1ps
`default_nettype none

module lrsl_front (
  input  wire                   clk,
  input  wire                   rst_n,
  lrsl_line_if.sink             in_line,
  output lrsl_pkg::q_wr_t       q_wr,
  input  wire                   q_full,
  output lrsl_pkg::line_desc_t  q_desc
);

  logic                         desc_valid_r, desc_valid_nxt;
  lrsl_pkg::line_desc_t         desc_r;
  lrsl_pkg::line_desc_t         desc_nxt;
  logic [lrsl_pkg::COORD_W-1:0] adx, ady, a0, a1, b0, b1, min_end;
  logic                         steep, swap, take, push;

  assign push         = desc_valid_r && !q_full;
  assign in_line.ready = !desc_valid_r || !q_full;
  assign take         = in_line.valid && in_line.ready;

  // classify: steepness, axis swap and end ordering
  always_comb begin
    adx   = (in_line.start_x > in_line.end_x) ? in_line.start_x - in_line.end_x
                                              : in_line.end_x - in_line.start_x;
    ady   = (in_line.start_y > in_line.end_y) ? in_line.start_y - in_line.end_y
                                              : in_line.end_y - in_line.start_y;
    steep = ady > adx;
    a0    = steep ? in_line.start_y : in_line.start_x;
    b0    = steep ? in_line.start_x : in_line.start_y;
    a1    = steep ? in_line.end_y   : in_line.end_x;
    b1    = steep ? in_line.end_x   : in_line.end_y;
    swap  = a0 > a1;
    desc_nxt.maj_start = swap ? a1 : a0;
    desc_nxt.maj_end   = swap ? a0 : a1;
    desc_nxt.min_start = swap ? b1 : b0;
    min_end            = swap ? b0 : b1;
    desc_nxt.dmaj      = desc_nxt.maj_end - desc_nxt.maj_start;
    desc_nxt.dmin      = (desc_nxt.min_start > min_end) ? desc_nxt.min_start - min_end
                                                        : min_end - desc_nxt.min_start;
    desc_nxt.min_dec   = !(desc_nxt.min_start < min_end);
    desc_nxt.steep     = steep;
    desc_nxt.color     = in_line.pixel_color;
  end

  // holding stage in front of the queue
  always_comb begin
    desc_valid_nxt = desc_valid_r;
    if (take) begin
      desc_valid_nxt = 1'b1;
    end else if (push) begin
      desc_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_valid_r <= 1'b0;
    end else begin
      desc_valid_r <= desc_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      desc_r <= desc_nxt;
    end
  end

  assign q_wr.push = push;
  assign q_wr.full = q_full;
  assign q_desc    = desc_r;

endmodule

`default_nettype wire

// ----- rtl/lrsl_queue.sv -----
// two-entry queue of line descriptors between front and back end
// depends on lrsl_pkg
`timescale 1ns / 1ps
`default_nettype none

module lrsl_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  lrsl_pkg::q_wr_t       wr,
  input  lrsl_pkg::line_desc_t  wr_desc,
  output logic                  full,
  input  lrsl_pkg::q_rd_t       rd,
  output logic                  empty,
  output lrsl_pkg::line_desc_t  rd_desc
);

  lrsl_pkg::line_desc_t        entry_r [lrsl_pkg::QUEUE_DEPTH];
  logic [lrsl_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lrsl_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lrsl_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        do_wr, do_rd;

  assign full    = cnt_r == lrsl_pkg::QCNT_W'(lrsl_pkg::QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_wr   = wr.push && !full;
  assign do_rd   = rd.pop && !empty;
  assign rd_desc = entry_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == lrsl_pkg::QPTR_W'(lrsl_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == lrsl_pkg::QPTR_W'(lrsl_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_desc;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lrsl_back.sv -----
// back end: bresenham stepper, serpentine index mapping and output register
// depends on lrsl_pkg and lrsl_pix_if; pulls descriptors from lrsl_queue
`timescale 1ns / 1ps
`default_nettype none

module lrsl_back (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire [lrsl_pkg::DIM_W-1:0]     grid_width,
  input  wire [lrsl_pkg::DIM_W-1:0]     grid_height,
  input  wire                           q_empty,
  input  lrsl_pkg::line_desc_t          q_desc,
  output lrsl_pkg::q_rd_t               q_rd,
  lrsl_pix_if.source                    out_pix
);

  lrsl_pkg::bk_state_t            state_r, state_nxt;
  logic [lrsl_pkg::COORD_W-1:0]   maj_r, maj_end_r, min_r, dmaj_r, dmin_r;
  logic signed [lrsl_pkg::ERR_W-1:0] err_r;
  logic                           min_dec_r, steep_r;
  logic [lrsl_pkg::COLOR_W-1:0]   color_r;

  logic                           out_valid_r;
  logic [lrsl_pkg::INDEX_W-1:0]   led_index_r;
  logic                           on_grid_r, last_r;
  logic [lrsl_pkg::COLOR_W-1:0]   color_out_r;

  logic                           adv, last, pop, minor_step;
  logic signed [lrsl_pkg::ERR_W:0]   err_sum, err_sub;
  logic signed [lrsl_pkg::ERR_W+1:0] err_twice;
  logic [lrsl_pkg::ERR_W-1:0]     err_nxt;
  logic [lrsl_pkg::COORD_W-1:0]   px, py;
  logic                           on_grid;
  logic [lrsl_pkg::DIM_W-1:0]     mx;
  logic [lrsl_pkg::DIM_W:0]       col;
  logic [2*lrsl_pkg::DIM_W:0]     base, idx_full;
  logic [lrsl_pkg::INDEX_W-1:0]   led_index;

  assign adv  = (state_r == lrsl_pkg::BK_DRAW) && (!out_valid_r || out_pix.ready);
  assign last = maj_r == maj_end_r;
  assign pop  = !q_empty && ((state_r == lrsl_pkg::BK_IDLE) || (adv && last));

  assign q_rd.pop   = pop;
  assign q_rd.empty = q_empty;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrsl_pkg::BK_IDLE: begin
        if (pop) begin
          state_nxt = lrsl_pkg::BK_DRAW;
        end
      end
      lrsl_pkg::BK_DRAW: begin
        if (adv && last && !pop) begin
          state_nxt = lrsl_pkg::BK_IDLE;
        end
      end
      default: state_nxt = lrsl_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrsl_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // error accumulator, minor axis steps on a tie
  always_comb begin
    err_sum    = {err_r[lrsl_pkg::ERR_W-1], err_r} + $signed({3'b000, dmin_r});
    err_twice  = {err_sum, 1'b0};
    minor_step = err_twice >= $signed({4'b0000, dmaj_r});
    err_sub    = err_sum - $signed({3'b000, dmaj_r});
    err_nxt    = minor_step ? err_sub[lrsl_pkg::ERR_W-1:0] : err_sum[lrsl_pkg::ERR_W-1:0];
  end

  // stepper registers
  always_ff @(posedge clk) begin
    if (pop) begin
      maj_r     <= q_desc.maj_start;
      maj_end_r <= q_desc.maj_end;
      min_r     <= q_desc.min_start;
      dmaj_r    <= q_desc.dmaj;
      dmin_r    <= q_desc.dmin;
      min_dec_r <= q_desc.min_dec;
      steep_r   <= q_desc.steep;
      color_r   <= q_desc.color;
      err_r     <= '0;
    end else if (adv) begin
      maj_r <= maj_r + 1'b1;
      err_r <= err_nxt;
      if (minor_step) begin
        min_r <= min_dec_r ? min_r - 1'b1 : min_r + 1'b1;
      end
    end
  end

  // serpentine mapping: mirrored column, odd columns run backwards
  always_comb begin
    px       = steep_r ? min_r : maj_r;
    py       = steep_r ? maj_r : min_r;
    on_grid  = ({1'b0, px} < grid_width) && ({1'b0, py} < grid_height);
    mx       = grid_width - 7'd1 - {1'b0, px};
    col      = mx[0] ? {1'b0, mx} + 8'd1 : {1'b0, mx};
    base     = {7'd0, col} * {8'd0, grid_height};
    idx_full = mx[0] ? base - 15'd1 - {9'd0, py} : base + {9'd0, py};
    led_index = on_grid ? idx_full[lrsl_pkg::INDEX_W-1:0] : '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_pix.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      led_index_r <= led_index;
      on_grid_r   <= on_grid;
      color_out_r <= color_r;
      last_r      <= last;
    end
  end

  assign out_pix.valid       = out_valid_r;
  assign out_pix.led_index   = led_index_r;
  assign out_pix.on_grid     = on_grid_r;
  assign out_pix.write_color = color_out_r;
  assign out_pix.last_pixel  = last_r;

endmodule

`default_nettype wire

// ----- rtl/line_raster_to_serpentine_leds.sv -----
// a line passes the front holding stage, a queue entry, the stepper registers
//   and the output register; one pixel per cycle while the output is not
//   stalled, set by the single bresenham stepper in the back end; a queued
//   line starts right after the previous last pixel
// reset: synchronous active-low rst_n clears handshakes and queue, grid 15x10
// top level: config registers, front end, descriptor queue, back end
`timescale 1ns / 1ps
`default_nettype none

module line_raster_to_serpentine_leds #(
  parameter int MAX_DIM = 64
) (
  input  wire                           clk,
  input  wire                           rst_n,
  lrsl_line_if.sink                     in_line,
  lrsl_pix_if.source                    out_pix,
  input  wire                           cfg_we,
  input  wire [0:0]                     cfg_index,
  input  wire [lrsl_pkg::DIM_W-1:0]     cfg_wdata
);

  logic [lrsl_pkg::DIM_W-1:0] grid_width_r, grid_height_r, cfg_sat;
  lrsl_pkg::q_wr_t            q_wr;
  lrsl_pkg::q_rd_t            q_rd;
  lrsl_pkg::line_desc_t       wr_desc, rd_desc;
  logic                       q_full, q_empty;

  // written values saturate to the largest grid dimension
  always_comb begin
    if (32'(cfg_wdata) > MAX_DIM) begin
      cfg_sat = lrsl_pkg::DIM_W'(MAX_DIM);
    end else begin
      cfg_sat = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= lrsl_pkg::GRID_WIDTH_RST;
      grid_height_r <= lrsl_pkg::GRID_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrsl_pkg::CFG_GRID_WIDTH:  grid_width_r  <= cfg_sat;
        lrsl_pkg::CFG_GRID_HEIGHT: grid_height_r <= cfg_sat;
        default: ;
      endcase
    end
  end

  lrsl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_line (in_line),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .q_desc  (wr_desc)
  );

  lrsl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_desc (wr_desc),
    .full    (q_full),
    .rd      (q_rd),
    .empty   (q_empty),
    .rd_desc (rd_desc)
  );

  lrsl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .grid_width  (grid_width_r),
    .grid_height (grid_height_r),
    .q_empty     (q_empty),
    .q_desc      (rd_desc),
    .q_rd        (q_rd),
    .out_pix     (out_pix)
  );

endmodule

`default_nettype wire

// ----- rtl/lrsl_checker.sv -----
// port-level checks for the line rasterizer and the bind to its top level
// depends on lrsl_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

module lrsl_checker (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         in_ready,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire [lrsl_pkg::INDEX_W-1:0] led_index,
  input wire                         on_grid,
  input wire [lrsl_pkg::COLOR_W-1:0] write_color,
  input wire                         last_pixel
);

  // no pixel pending right after reset
  a_reset_out_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("pixel valid right after reset");

  // front end empty after reset, so a line can be taken at once
  a_reset_in_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  // off-grid pixels carry index zero
  a_offgrid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !on_grid |-> led_index == '0)
    else $error("off-grid pixel with nonzero index");

  // a stalled pixel write holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(led_index) && $stable(on_grid)
      && $stable(write_color) && $stable(last_pixel))
    else $error("stalled pixel changed");

endmodule

bind line_raster_to_serpentine_leds lrsl_checker u_lrsl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_line.ready),
  .out_valid   (out_pix.valid),
  .out_ready   (out_pix.ready),
  .led_index   (out_pix.led_index),
  .on_grid     (out_pix.on_grid),
  .write_color (out_pix.write_color),
  .last_pixel  (out_pix.last_pixel)
);

`default_nettype wire

// ----- test/line_raster_to_serpentine_leds_test.sv -----
// testbench for the line rasterizer with serpentine led mapping
// predicts every pixel write with its own bresenham stepper and checks each transfer in order
// depends on lrsl_pkg, lrsl_line_if, lrsl_pix_if and line_raster_to_serpentine_leds
`timescale 1ns / 1ps

module line_raster_to_serpentine_leds_test;

  localparam int MAX_DIM    = 64;
  localparam int DRAIN_MAX  = 40000;
  localparam int SETTLE_CYC = 8;

  typedef struct packed {
    logic [lrsl_pkg::COORD_W-1:0] start_x;
    logic [lrsl_pkg::COORD_W-1:0] start_y;
    logic [lrsl_pkg::COORD_W-1:0] end_x;
    logic [lrsl_pkg::COORD_W-1:0] end_y;
    logic [lrsl_pkg::COLOR_W-1:0] color;
  } line_req_t;

  typedef struct packed {
    logic [lrsl_pkg::INDEX_W-1:0] led_index;
    logic                         on_grid;
    logic [lrsl_pkg::COLOR_W-1:0] write_color;
    logic                         last_pixel;
  } pixel_wr_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [0:0]                 cfg_index;
  logic [lrsl_pkg::DIM_W-1:0] cfg_wdata;

  lrsl_line_if line_ch();
  lrsl_pix_if  pix_ch();

  line_raster_to_serpentine_leds #(.MAX_DIM(MAX_DIM)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_line   (line_ch),
    .out_pix   (pix_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // grid shadow and pixels still owed by the block
  int        grid_w = lrsl_pkg::GRID_WIDTH_RST;
  int        grid_h = lrsl_pkg::GRID_HEIGHT_RST;
  pixel_wr_t pending_pixels[$];
  int        fail_count = 0;
  int        gap_max = 15;
  int        stall_max = 15;
  int        hold_off = 0;

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // safety net
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // strip index of one pixel under the current grid
  function automatic pixel_wr_t map_led(input int x, input int y);
    pixel_wr_t px;
    int        mx;
    int        idx;
    px = '0;
    if (x >= grid_w || y >= grid_h) begin
      px.led_index = '0;
      px.on_grid   = 1'b0;
    end else begin
      mx = grid_w - 1 - x;
      if (mx % 2 == 1) idx = (mx + 1) * grid_h - 1 - y;
      else idx = mx * grid_h + y;
      px.led_index = idx[lrsl_pkg::INDEX_W-1:0];
      px.on_grid   = 1'b1;
    end
    return px;
  endfunction

  // bresenham walk, queues one expected write per pixel
  function automatic void trace_line(input line_req_t ln);
    int        x0, y0, x1, y1, t;
    int        adx, ady, dmaj, dmin, err, ystep, yv, xv;
    bit        steep;
    pixel_wr_t px;
    x0 = ln.start_x;
    y0 = ln.start_y;
    x1 = ln.end_x;
    y1 = ln.end_y;
    adx = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady = (y1 > y0) ? y1 - y0 : y0 - y1;
    steep = ady > adx;
    if (steep) begin
      t = x0; x0 = y0; y0 = t;
      t = x1; x1 = y1; y1 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    dmaj  = x1 - x0;
    dmin  = (y1 > y0) ? y1 - y0 : y0 - y1;
    ystep = (y0 < y1) ? 1 : -1;
    err   = 0;
    yv    = y0;
    for (xv = x0; xv <= x1; xv++) begin
      if (steep) px = map_led(yv, xv);
      else px = map_led(xv, yv);
      px.write_color = ln.color;
      px.last_pixel  = (xv == x1);
      pending_pixels.push_back(px);
      err += dmin;
      // minor axis steps on a tie too
      if (2 * err >= dmaj) begin
        yv  += ystep;
        err -= dmaj;
      end
    end
  endfunction

  function automatic line_req_t line_of(input int x0, input int y0, input int x1,
                                        input int y1, input int color);
    line_req_t ln;
    ln.start_x = lrsl_pkg::COORD_W'(x0);
    ln.start_y = lrsl_pkg::COORD_W'(y0);
    ln.end_x   = lrsl_pkg::COORD_W'(x1);
    ln.end_y   = lrsl_pkg::COORD_W'(y1);
    ln.color   = lrsl_pkg::COLOR_W'(color);
    return ln;
  endfunction

  // coordinates mostly near the grid, sometimes anywhere in range
  function automatic int pick_coord();
    int span;
    span = (grid_w > grid_h) ? grid_w : grid_h;
    span = span + 2;
    if (span > 64) span = 64;
    if ($urandom_range(3, 0) == 0) return $urandom_range(63, 0);
    return $urandom_range(span - 1, 0);
  endfunction

  function automatic line_req_t random_line();
    return line_of(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                   $urandom_range(65535, 0));
  endfunction

  // one line transfer; valid is left high so a back-to-back line follows without a dip
  task automatic send_line(input line_req_t ln);
    int gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      line_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    line_ch.valid       <= 1'b1;
    line_ch.start_x     <= ln.start_x;
    line_ch.start_y     <= ln.start_y;
    line_ch.end_x       <= ln.end_x;
    line_ch.end_y       <= ln.end_y;
    line_ch.pixel_color <= ln.color;
    do @(posedge clk); while (!line_ch.ready);
    trace_line(ln);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_line(random_line());
  endtask

  // stop offering and wait for every owed pixel
  task automatic wait_all_written();
    int waited;
    waited = 0;
    line_ch.valid <= 1'b0;
    while (pending_pixels.size() > 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    if (pending_pixels.size() > 0) begin
      $error("%0d expected pixel writes never arrived", pending_pixels.size());
      fail_count++;
      pending_pixels.delete();
    end
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // register write; the enable is lowered by the caller
  task automatic cfg_write(input lrsl_pkg::cfg_reg_t idx, input int value);
    int v;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[lrsl_pkg::DIM_W-1:0];
    @(posedge clk);
    v = value & 'h7f;
    if (v > MAX_DIM) v = MAX_DIM;
    if (idx == lrsl_pkg::CFG_GRID_WIDTH) grid_w = v;
    else grid_h = v;
  endtask

  task automatic set_grid(input int w, input int h);
    wait_all_written();
    cfg_write(lrsl_pkg::CFG_GRID_WIDTH, w);
    cfg_write(lrsl_pkg::CFG_GRID_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  // pixel receiver and checker
  initial begin : pixel_sink
    int        stall;
    pixel_wr_t exp_px;
    pix_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off > 0) begin
        stall    = hold_off;
        hold_off = 0;
      end else begin
        stall = $urandom_range(stall_max, 0);
      end
      if (stall > 0) begin
        pix_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pix_ch.ready <= 1'b1;
      do @(posedge clk); while (!pix_ch.valid);
      if (pending_pixels.size() == 0) begin
        $error("pixel write with none expected: led_index %0d", pix_ch.led_index);
        fail_count++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (pix_ch.led_index !== exp_px.led_index) begin
          $error("led_index mismatch: expected %0d, actual %0d",
                 exp_px.led_index, pix_ch.led_index);
          fail_count++;
        end
        if (pix_ch.on_grid !== exp_px.on_grid) begin
          $error("on_grid mismatch: expected %0d, actual %0d",
                 exp_px.on_grid, pix_ch.on_grid);
          fail_count++;
        end
        if (pix_ch.write_color !== exp_px.write_color) begin
          $error("write_color mismatch: expected %0h, actual %0h",
                 exp_px.write_color, pix_ch.write_color);
          fail_count++;
        end
        if (pix_ch.last_pixel !== exp_px.last_pixel) begin
          $error("last_pixel mismatch: expected %0d, actual %0d",
                 exp_px.last_pixel, pix_ch.last_pixel);
          fail_count++;
        end
      end
    end
  end

  // directed lines on the reset grid of 15 x 10
  task automatic test_reset_grid();
    send_line(line_of(3, 4, 3, 4, 'h0000));     // single point
    send_line(line_of(0, 0, 14, 0, 'hffff));    // horizontal, left to right
    send_line(line_of(14, 9, 0, 9, 'h1234));    // horizontal, right to left
    send_line(line_of(0, 0, 0, 9, 'h5555));     // vertical down
    send_line(line_of(5, 9, 5, 0, 'haaaa));     // vertical up
    send_line(line_of(0, 0, 9, 9, 'h0f0f));     // diagonals, all four ways
    send_line(line_of(9, 0, 0, 9, 'hf0f0));
    send_line(line_of(0, 9, 9, 0, 'h00ff));
    send_line(line_of(9, 9, 0, 0, 'hff00));
    send_line(line_of(0, 0, 14, 3, 'h7777));    // shallow
    send_line(line_of(2, 0, 6, 9, 'h8888));     // steep
    send_line(line_of(0, 0, 2, 1, 'h0001));     // error tie, shallow
    send_line(line_of(0, 0, 1, 2, 'h8000));     // error tie, steep
    send_line(line_of(20, 20, 30, 25, 'hbeef)); // fully off grid
    send_line(line_of(10, 5, 20, 8, 'hcafe));   // leaves the grid
    send_line(line_of(0, 0, 63, 63, 'h5a5a));   // coordinate extremes
    send_line(line_of(63, 0, 0, 63, 'ha5a5));
    send_line(line_of(63, 63, 63, 63, 'hffff));
    send_line(line_of(0, 63, 63, 0, 'h0000));
    send_line(line_of(0, 0, 63, 1, 'h3c3c));
    send_random(30);
  endtask

  task automatic test_full_grid();
    set_grid(64, 64);
    send_line(line_of(0, 0, 63, 63, 'h1111));
    send_line(line_of(63, 0, 0, 63, 'h2222));
    send_random(80);
  endtask

  // one-pixel grid and grids with a zero register
  task automatic test_tiny_and_zero();
    set_grid(1, 1);
    send_line(line_of(0, 0, 0, 0, 'h4242));
    send_line(line_of(0, 0, 3, 2, 'h2424));
    send_random(6);
    set_grid(0, 10);
    send_line(line_of(0, 0, 5, 5, 'h9999));
    send_random(6);
    set_grid(64, 0);
    send_line(line_of(0, 0, 63, 0, 'h6666));
    send_random(6);
  endtask

  // values above the largest grid clamp to it
  task automatic test_saturation();
    set_grid(127, 65);
    send_line(line_of(0, 0, 63, 63, 'hdead));
    send_line(line_of(63, 5, 0, 40, 'hface));
    send_random(20);
  endtask

  task automatic test_random_grids();
    int round;
    for (round = 0; round < 4; round++) begin
      set_grid($urandom_range(64, 1), $urandom_range(64, 1));
      // one round with both sides at full rate
      if (round == 2) begin
        gap_max   = 0;
        stall_max = 0;
      end
      send_random(25);
      gap_max   = 15;
      stall_max = 15;
    end
  endtask

  // receiver holds off while lines keep coming, so the input stalls
  task automatic test_backpressure();
    set_grid($urandom_range(64, 1), $urandom_range(64, 1));
    gap_max  = 0;
    hold_off = 300;
    send_random(12);
    gap_max = 15;
  endtask

  // sender waits for all pixels before going on
  task automatic test_sender_pause();
    set_grid(15, 10);
    send_random(10);
    wait_all_written();
    send_random(10);
  endtask

  // main sequence
  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= lrsl_pkg::CFG_GRID_WIDTH;
    cfg_wdata           <= '0;
    line_ch.valid       <= 1'b0;
    line_ch.start_x     <= '0;
    line_ch.start_y     <= '0;
    line_ch.end_x       <= '0;
    line_ch.end_y       <= '0;
    line_ch.pixel_color <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_grid();
    test_full_grid();
    test_tiny_and_zero();
    test_saturation();
    test_random_grids();
    test_backpressure();
    test_sender_pause();
    wait_all_written();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
